@@ design/ipbf_pkg.sv @@
// shared types and codes for the ip/port blocklist filter
// holds the item struct that walks the cell chain and the result codes
// no dependencies
package ipbf_pkg;

	// item kinds
	localparam logic MODE_CHECK = 1'b0;
	localparam logic MODE_RULE  = 1'b1;

	// table selectors
	localparam logic [1:0] TBL_SRC_ADDR = 2'd0;
	localparam logic [1:0] TBL_DST_ADDR = 2'd1;
	localparam logic [1:0] TBL_SRC_PORT = 2'd2;
	localparam logic [1:0] TBL_DST_PORT = 2'd3;

	// protocols that enable the port checks
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam int NUM_TABLES = 4;
	localparam int DEFAULT_RULE_DEPTH = 256;

	typedef enum logic [2:0] {
		RSN_PASS     = 3'd0,
		RSN_SRC_ADDR = 3'd1,
		RSN_DST_ADDR = 3'd2,
		RSN_SRC_PORT = 3'd3,
		RSN_DST_PORT = 3'd4,
		RSN_STORED   = 3'd5,
		RSN_FULL     = 3'd6
	} reason_t;

	// one item in flight along the chain
	typedef struct packed {
		logic        mode;
		logic [1:0]  sel;
		logic        full;
		logic [31:0] rule;
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic        ports_on;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [NUM_TABLES-1:0] hit;
	} item_t;

endpackage

@@ design/ipbf_cell.sv @@
// one cell of the blocklist chain: one entry of each of the four tables
// compares the passing packet, stores a passing rule, hands the item on
// depends on ipbf_pkg
module ipbf_cell #(
	parameter int CW    = 9,
	parameter int INDEX = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   vld_in,
	input  ipbf_pkg::item_t        item_in,
	input  logic [3:0][CW-1:0]     cnt_in,
	output logic                   vld_out,
	output ipbf_pkg::item_t        item_out,
	output logic [3:0][CW-1:0]     cnt_out
);
	import ipbf_pkg::*;

	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic [31:0] src_addr_q;
	logic [31:0] dst_addr_q;
	logic [15:0] src_port_q;
	logic [15:0] dst_port_q;

	logic                vld_s1;
	item_t               item_s1;
	logic [3:0][CW-1:0]  cnt_s1;

	logic       wr_en;
	logic [3:0] live;
	item_t      item_nxt;

	// entry is in use for this item when its index is below the table count
	always_comb begin
		for (int t = 0; t < NUM_TABLES; t++) begin
			live[t] = IDX < cnt_in[t];
		end
	end

	// a rule lands here when the count seen at its acceptance points at this cell
	assign wr_en = adv && vld_in && (item_in.mode == MODE_RULE) && !item_in.full &&
		(cnt_in[item_in.sel] == IDX);

	// entry store, written once per rule
	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (item_in.sel)
				TBL_SRC_ADDR: src_addr_q <= item_in.rule;
				TBL_DST_ADDR: dst_addr_q <= item_in.rule;
				TBL_SRC_PORT: src_port_q <= item_in.rule[15:0];
				TBL_DST_PORT: dst_port_q <= item_in.rule[15:0];
				default:      src_addr_q <= src_addr_q;
			endcase
		end
	end

	// fold this cell's matches into the item
	always_comb begin
		item_nxt = item_in;
		if (item_in.mode == MODE_CHECK) begin
			item_nxt.hit[TBL_SRC_ADDR] = item_in.hit[TBL_SRC_ADDR] |
				(live[TBL_SRC_ADDR] && (src_addr_q == item_in.saddr));
			item_nxt.hit[TBL_DST_ADDR] = item_in.hit[TBL_DST_ADDR] |
				(live[TBL_DST_ADDR] && (dst_addr_q == item_in.daddr));
			item_nxt.hit[TBL_SRC_PORT] = item_in.hit[TBL_SRC_PORT] |
				(item_in.ports_on && live[TBL_SRC_PORT] && (src_port_q == item_in.sport));
			item_nxt.hit[TBL_DST_PORT] = item_in.hit[TBL_DST_PORT] |
				(item_in.ports_on && live[TBL_DST_PORT] && (dst_port_q == item_in.dport));
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_nxt;
			cnt_s1  <= cnt_in;
		end
	end

	assign vld_out  = vld_s1;
	assign item_out = item_s1;
	assign cnt_out  = cnt_s1;

endmodule

@@ design/ip_port_blocklist_filter_core.sv @@
// Packet verdict engine over four blocklist tables (source and destination
// address, source and destination port), built as a chain of RULE_DEPTH cells
// with one entry of each table per cell. Every item walks the whole chain, one
// cell per cycle while the output is not stalled, and then the output register;
// a new item is taken every cycle that the output is not stalled. The chain
// and the output register move together and hold while the output is stalled.
// A rule item carries the table count seen at its transfer and is stored by the
// cell with that index; later packets reach that cell after it and see it.
// Tables start empty after reset; no clearing pass is needed.
// depends on ipbf_pkg and ipbf_cell
module ip_port_blocklist_filter_core #(
	parameter int RULE_DEPTH = ipbf_pkg::DEFAULT_RULE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// rule_value, source_address, dest_address, protocol_number,
	// source_port_field, dest_port_field
	input  logic [135:0] s_axis_tdata,
	// mode, table_select
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// verdict, reason_code, zero fill
	output logic [7:0]   m_axis_tdata
);
	import ipbf_pkg::*;

	localparam int CW = $clog2(RULE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(RULE_DEPTH);

	logic               adv;
	logic               in_xfer;
	logic [3:0][CW-1:0] cnt_q;
	item_t              head;

	logic               vld_chain [0:RULE_DEPTH];
	item_t              item_chain[0:RULE_DEPTH];
	logic [3:0][CW-1:0] cnt_chain [0:RULE_DEPTH];

	logic               out_vld_q;
	logic               verdict_q;
	reason_t            reason_q;
	reason_t            reason_nxt;

	// chain moves when the output register is free or being emptied
	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign in_xfer       = s_axis_tvalid && adv;

	// unpack the incoming item
	always_comb begin
		head.mode     = s_axis_tuser[0];
		head.sel      = s_axis_tuser[2:1];
		head.full     = cnt_q[s_axis_tuser[2:1]] == FULL_CNT;
		head.rule     = s_axis_tdata[31:0];
		head.saddr    = s_axis_tdata[63:32];
		head.daddr    = s_axis_tdata[95:64];
		head.ports_on = (s_axis_tdata[103:96] == PROTO_TCP) ||
			(s_axis_tdata[103:96] == PROTO_UDP);
		head.sport    = s_axis_tdata[119:104];
		head.dport    = s_axis_tdata[135:120];
		head.hit      = '0;
	end

	// table fill counts, bumped when a rule is taken and its table is not full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_xfer && (head.mode == MODE_RULE) && !head.full) begin
			cnt_q[head.sel] <= cnt_q[head.sel] + CW'(1);
		end
	end

	assign vld_chain[0]  = s_axis_tvalid;
	assign item_chain[0] = head;
	assign cnt_chain[0]  = cnt_q;

	// row of cells
	for (genvar i = 0; i < RULE_DEPTH; i++) begin : g_cell
		ipbf_cell #(
			.CW    (CW),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.vld_in   (vld_chain[i]),
			.item_in  (item_chain[i]),
			.cnt_in   (cnt_chain[i]),
			.vld_out  (vld_chain[i+1]),
			.item_out (item_chain[i+1]),
			.cnt_out  (cnt_chain[i+1])
		);
	end

	// result code from the item leaving the chain, first match wins
	always_comb begin
		if (item_chain[RULE_DEPTH].mode == MODE_RULE) begin
			reason_nxt = item_chain[RULE_DEPTH].full ? RSN_FULL : RSN_STORED;
		end else if (item_chain[RULE_DEPTH].hit[TBL_SRC_ADDR]) begin
			reason_nxt = RSN_SRC_ADDR;
		end else if (item_chain[RULE_DEPTH].hit[TBL_DST_ADDR]) begin
			reason_nxt = RSN_DST_ADDR;
		end else if (item_chain[RULE_DEPTH].hit[TBL_SRC_PORT]) begin
			reason_nxt = RSN_SRC_PORT;
		end else if (item_chain[RULE_DEPTH].hit[TBL_DST_PORT]) begin
			reason_nxt = RSN_DST_PORT;
		end else begin
			reason_nxt = RSN_PASS;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_chain[RULE_DEPTH];
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv) begin
			reason_q  <= reason_nxt;
			verdict_q <= (item_chain[RULE_DEPTH].mode == MODE_CHECK) && (reason_nxt != RSN_PASS);
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {4'b0000, reason_q, verdict_q};

`ifndef SYNTH
	// a table count never runs past the depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= FULL_CNT) && (cnt_q[1] <= FULL_CNT) &&
		(cnt_q[2] <= FULL_CNT) && (cnt_q[3] <= FULL_CNT))
		else $error("table count above depth");

	// a rule taken on a full table leaves the counts alone
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (s_axis_tuser[0] == MODE_RULE) && head.full) |=> $stable(cnt_q))
		else $error("full table count changed");

	// drop verdict goes with a match code and only with one
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (verdict_q == ((reason_q == RSN_SRC_ADDR) ||
			(reason_q == RSN_DST_ADDR) || (reason_q == RSN_SRC_PORT) ||
			(reason_q == RSN_DST_PORT))))
		else $error("verdict does not match reason");
`endif

endmodule

@@ tb/ip_port_blocklist_filter_core_test.sv @@
// self-checking testbench for ip_port_blocklist_filter_core
// a scoreboard class keeps its own copy of the four blocklists and predicts every verdict
// depends on ipbf_pkg and the core rtl
import ipbf_pkg::*;

typedef struct packed {
	logic    verdict;
	reason_t reason;
} verdict_t;

class blocklist_scoreboard #(int DEPTH = 256);
	logic [31:0] src_addrs[DEPTH];
	logic [31:0] dst_addrs[DEPTH];
	logic [15:0] src_ports[DEPTH];
	logic [15:0] dst_ports[DEPTH];
	int unsigned fill[NUM_TABLES];
	verdict_t    pending_verdicts[$];
	int unsigned errors;
	int unsigned reason_seen[8];

	function new();
		foreach (fill[t]) fill[t] = 0;
		foreach (reason_seen[r]) reason_seen[r] = 0;
		errors = 0;
	endfunction

	// only the entries below a table's fill level take part in a lookup
	function bit listed(logic [1:0] t, logic [31:0] v);
		for (int unsigned i = 0; i < fill[t]; i++) begin
			case (t)
				TBL_SRC_ADDR: if (src_addrs[i] == v) return 1'b1;
				TBL_DST_ADDR: if (dst_addrs[i] == v) return 1'b1;
				TBL_SRC_PORT: if (src_ports[i] == v[15:0]) return 1'b1;
				default:      if (dst_ports[i] == v[15:0]) return 1'b1;
			endcase
		end
		return 1'b0;
	endfunction

	// work out the verdict of one accepted input transfer
	function void note_transfer(logic mode, logic [1:0] sel, logic [31:0] rule,
			logic [31:0] saddr, logic [31:0] daddr, logic [7:0] proto,
			logic [15:0] sport, logic [15:0] dport);
		verdict_t v;
		logic     ports_on;
		v.verdict = 1'b0;
		v.reason = RSN_PASS;
		ports_on = (proto == PROTO_TCP) || (proto == PROTO_UDP);
		if (mode == MODE_RULE) begin
			if (fill[sel] >= DEPTH) begin
				v.reason = RSN_FULL;
			end else begin
				case (sel)
					TBL_SRC_ADDR: src_addrs[fill[sel]] = rule;
					TBL_DST_ADDR: dst_addrs[fill[sel]] = rule;
					TBL_SRC_PORT: src_ports[fill[sel]] = rule[15:0];
					default:      dst_ports[fill[sel]] = rule[15:0];
				endcase
				fill[sel]++;
				v.reason = RSN_STORED;
			end
		end else begin
			// first hit wins: addresses, then ports for tcp and udp only
			if (listed(TBL_SRC_ADDR, saddr))
				v.reason = RSN_SRC_ADDR;
			else if (listed(TBL_DST_ADDR, daddr))
				v.reason = RSN_DST_ADDR;
			else if (ports_on && listed(TBL_SRC_PORT, {16'h0, sport}))
				v.reason = RSN_SRC_PORT;
			else if (ports_on && listed(TBL_DST_PORT, {16'h0, dport}))
				v.reason = RSN_DST_PORT;
			v.verdict = (v.reason != RSN_PASS);
		end
		pending_verdicts.push_back(v);
	endfunction

	// compare one output transfer with the oldest predicted verdict
	function void check_result(logic verdict, logic [2:0] reason);
		verdict_t want;
		if (pending_verdicts.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected output transfer: verdict %0d reason %0d", verdict, reason);
			return;
		end
		want = pending_verdicts.pop_front();
		reason_seen[want.reason]++;
		if (verdict !== want.verdict || reason !== want.reason) begin
			errors++;
			if (errors <= 10)
				$display("verdict error: expected verdict %0d reason %0d, got verdict %0d reason %0d",
					want.verdict, want.reason, verdict, reason);
		end
	endfunction
endclass

module ip_port_blocklist_filter_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RULE_DEPTH   = DEFAULT_RULE_DEPTH;
	localparam int RANDOM_ITEMS = 100;
	localparam int STALL_LIMIT  = 20 * (RULE_DEPTH + 1);

	localparam logic [31:0] HOST_A = 32'hC0A8_0001;
	localparam logic [31:0] HOST_B = 32'hFFFF_FFFF;
	localparam logic [31:0] HOST_C = 32'h0A00_0005;
	localparam logic [15:0] PORT_S = 16'h0050;
	localparam logic [15:0] PORT_D = 16'h01BB;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// rule_value, source_address, dest_address, protocol_number,
	// source_port_field, dest_port_field
	logic [135:0] s_axis_tdata;
	// mode, table_select
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// verdict, reason_code, zero fill
	logic [7:0]   m_axis_tdata;

	blocklist_scoreboard #(RULE_DEPTH) sb;
	int unsigned idle_cycles = 0;
	int unsigned burst_left = 0;
	logic [9:0]  ready_tick = '0;
	int unsigned sent = 0;

	ip_port_blocklist_filter_core #(
		.RULE_DEPTH(RULE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver back-pressure, cycling through four styles
	always @(negedge clk) begin
		ready_tick <= ready_tick + 1'b1;
		case (ready_tick[9:8])
			2'd0:    m_axis_tready <= 1'b1;
			2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
			2'd2:    m_axis_tready <= (ready_tick[3:0] < 4'd11);
			default: m_axis_tready <= 1'($urandom_range(0, 1));
		endcase
	end

	// watch both sides at the rising edge
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_transfer(s_axis_tuser[0], s_axis_tuser[2:1], s_axis_tdata[31:0],
				s_axis_tdata[63:32], s_axis_tdata[95:64], s_axis_tdata[103:96],
				s_axis_tdata[119:104], s_axis_tdata[135:120]);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata[0], m_axis_tdata[3:1]);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("no transfer for %0d cycles, %0d verdicts outstanding",
					idle_cycles, sb.pending_verdicts.size());
				$display("ip_port_blocklist_filter_core: mismatch");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// one input transfer, then maybe a gap between bursts
	task automatic send_item(input logic mode, input logic [1:0] sel, input logic [31:0] rule,
			input logic [31:0] saddr, input logic [31:0] daddr, input logic [7:0] proto,
			input logic [15:0] sport, input logic [15:0] dport);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= {sel, mode};
		s_axis_tdata <= {dport, sport, proto, daddr, saddr, rule};
		do @(posedge clk); while (!s_axis_tready);
		sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0)
				repeat ($urandom_range(1, 6)) begin
					@(negedge clk);
					s_axis_tvalid <= 1'b0;
				end
		end else begin
			burst_left--;
		end
	endtask

	// hold the sender off until every verdict is back
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending_verdicts.size() != 0) @(posedge clk);
	endtask

	// addresses: often one already listed, sometimes an extreme
	function automatic logic [31:0] pick_addr(logic [1:0] t);
		int unsigned n;
		n = sb.fill[t];
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3:
				if (n != 0) begin
					if (t == TBL_SRC_ADDR) return sb.src_addrs[$urandom_range(0, n - 1)];
					return sb.dst_addrs[$urandom_range(0, n - 1)];
				end
			default: ;
		endcase
		return $urandom;
	endfunction

	function automatic logic [15:0] pick_port(logic [1:0] t);
		int unsigned n;
		n = sb.fill[t];
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4:
				if (n != 0) begin
					if (t == TBL_SRC_PORT) return sb.src_ports[$urandom_range(0, n - 1)];
					return sb.dst_ports[$urandom_range(0, n - 1)];
				end
			default: ;
		endcase
		return 16'($urandom);
	endfunction

	function automatic logic [7:0] pick_proto();
		case ($urandom_range(0, 5))
			0, 1:    return PROTO_TCP;
			2, 3:    return PROTO_UDP;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_packet();
		send_item(MODE_CHECK, 2'($urandom_range(0, 3)), $urandom, pick_addr(TBL_SRC_ADDR),
			pick_addr(TBL_DST_ADDR), pick_proto(), pick_port(TBL_SRC_PORT),
			pick_port(TBL_DST_PORT));
	endtask

	// rule with random packet fields, which the block ignores
	task automatic random_rule(input logic [1:0] sel);
		logic [31:0] value;
		case ($urandom_range(0, 7))
			0:       value = '0;
			1:       value = '1;
			default: value = $urandom;
		endcase
		send_item(MODE_RULE, sel, value, $urandom, $urandom, 8'($urandom_range(0, 255)),
			16'($urandom), 16'($urandom));
	endtask

	initial begin
		int unsigned room;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		sb = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// empty tables pass everything, extremes included
		send_item(MODE_CHECK, TBL_SRC_ADDR, '0, '0, '0, 8'd0, '0, '0);
		send_item(MODE_CHECK, TBL_DST_PORT, '1, '1, '1, PROTO_TCP, '1, '1);
		// one rule per table; port rules keep only the low half
		send_item(MODE_RULE, TBL_SRC_ADDR, HOST_A, '1, '1, PROTO_TCP, '1, '1);
		send_item(MODE_RULE, TBL_DST_ADDR, HOST_B, '0, '0, 8'd0, '0, '0);
		send_item(MODE_RULE, TBL_SRC_PORT, {16'hABCD, PORT_S}, '0, '0, PROTO_UDP, '0, '0);
		send_item(MODE_RULE, TBL_DST_PORT, {16'h1234, PORT_D}, '0, '0, PROTO_TCP, '0, '0);
		// each table hit, and the priority between them
		send_item(MODE_CHECK, TBL_DST_ADDR, '1, HOST_A, HOST_C, 8'd1, '0, '0);
		send_item(MODE_CHECK, TBL_SRC_ADDR, '0, HOST_A, HOST_B, PROTO_TCP, PORT_S, PORT_D);
		send_item(MODE_CHECK, TBL_SRC_ADDR, '0, HOST_C, HOST_B, PROTO_TCP, PORT_S, PORT_D);
		send_item(MODE_CHECK, TBL_SRC_ADDR, '0, HOST_C, HOST_C, PROTO_TCP, PORT_S, 16'd1);
		send_item(MODE_CHECK, TBL_SRC_ADDR, '0, HOST_C, HOST_C, PROTO_UDP, PORT_S, PORT_D);
		send_item(MODE_CHECK, TBL_SRC_ADDR, '0, HOST_C, HOST_C, PROTO_UDP, 16'd2, PORT_D);
		// other protocols skip the port checks
		send_item(MODE_CHECK, TBL_SRC_ADDR, '0, HOST_C, HOST_C, 8'd1, PORT_S, PORT_D);
		send_item(MODE_CHECK, TBL_SRC_ADDR, '0, HOST_C, HOST_C, 8'd255, PORT_S, PORT_D);
		send_item(MODE_CHECK, TBL_SRC_ADDR, '0, HOST_C, HOST_C, 8'd7, PORT_S, PORT_D);
		send_item(MODE_CHECK, TBL_SRC_ADDR, '0, HOST_C, HOST_C, 8'd16, 16'd3, PORT_D);
		// upper half of a port rule must not match
		send_item(MODE_CHECK, TBL_SRC_ADDR, '0, HOST_C, HOST_C, PROTO_TCP, 16'hABCD, 16'h1234);
		// zero as a rule and as a packet address
		send_item(MODE_RULE, TBL_SRC_ADDR, '0, '1, '1, PROTO_UDP, '1, '1);
		send_item(MODE_CHECK, TBL_DST_ADDR, '1, '0, HOST_C, 8'd0, '0, '0);
		send_item(MODE_CHECK, TBL_DST_ADDR, '1, HOST_C, '1, PROTO_UDP, '1, '1);
		drain();

		// mixed rules and packets
		repeat (RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 3) random_rule(2'($urandom_range(0, 3)));
			else random_packet();
		end
		drain();

		// fill the destination port table to the brim, then past it
		room = RULE_DEPTH - sb.fill[TBL_DST_PORT];
		repeat (room) begin
			random_rule(TBL_DST_PORT);
			if ($urandom_range(0, 7) == 0) random_packet();
		end
		repeat (2) random_rule(TBL_DST_PORT);

		// a full table against random traffic
		repeat (40) begin
			if ($urandom_range(0, 5) == 0) random_rule(2'($urandom_range(0, 3)));
			else random_packet();
		end
		drain();
		repeat (RULE_DEPTH + 10) @(posedge clk);

		$display("%0d transfers sent: %0d rules stored, %0d refused on a full table",
			sent, sb.reason_seen[RSN_STORED], sb.reason_seen[RSN_FULL]);
		$display("packets passed %0d, dropped by src/dst addr %0d/%0d, src/dst port %0d/%0d",
			sb.reason_seen[RSN_PASS], sb.reason_seen[RSN_SRC_ADDR],
			sb.reason_seen[RSN_DST_ADDR], sb.reason_seen[RSN_SRC_PORT],
			sb.reason_seen[RSN_DST_PORT]);
		if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
			$display("ip_port_blocklist_filter_core: match");
		end else begin
			$display("%0d errors, %0d verdicts never seen", sb.errors,
				sb.pending_verdicts.size());
			$display("ip_port_blocklist_filter_core: mismatch");
		end
		$finish;
	end

endmodule

@@ ip_port_blocklist_filter_core.f @@
design/ipbf_pkg.sv
design/ipbf_cell.sv
design/ip_port_blocklist_filter_core.sv
tb/ip_port_blocklist_filter_core_test.sv
